// File: rtl/htw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package htw_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int BUCKET_BITS_DEF = 8;
   localparam int MAX_RESULTS     = 32;
   localparam int FIRE_CNT_W      = $clog2(MAX_RESULTS);

   // request modes
   localparam logic [1:0] MODE_SCHED  = 2'd0;
   localparam logic [1:0] MODE_CANCEL = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;
   localparam logic [1:0] MODE_QUERY  = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_SCHED  = 3'd0;
   localparam logic [2:0] KIND_CANCEL = 3'd1;
   localparam logic [2:0] KIND_FIRED  = 3'd2;
   localparam logic [2:0] KIND_NONE   = 3'd3;
   localparam logic [2:0] KIND_QUERY  = 3'd4;

   // slot scan operations
   localparam logic [1:0] SCAN_CANCEL = 2'd0;
   localparam logic [1:0] SCAN_MARK   = 2'd1;
   localparam logic [1:0] SCAN_FIND   = 2'd2;
   localparam logic [1:0] SCAN_QUERY  = 2'd3;

   // result builders
   localparam logic [2:0] EMIT_SCHED  = 3'd0;
   localparam logic [2:0] EMIT_CANCEL = 3'd1;
   localparam logic [2:0] EMIT_FIRE   = 3'd2;
   localparam logic [2:0] EMIT_NONE   = 3'd3;
   localparam logic [2:0] EMIT_QUERY  = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] delay_ticks;
      logic [31:0] target_id;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        timer_id;
      logic               ok;
      logic signed [31:0] next_expiry;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       issue;
      logic [1:0] scan_op;
      logic       clear_best;
      logic       qcalc;
      logic       emit;
      logic [2:0] emit_sel;
      logic       fire_final;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic any_due;
      logic fire_last;
   } sts_type;

endpackage
`default_nettype wire

// File: rtl/htw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module htw_datapath #(
   parameter int TABLE_DEPTH = htw_pkg::TABLE_DEPTH_DEF,
   parameter int BUCKET_BITS = htw_pkg::BUCKET_BITS_DEF,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire htw_pkg::cmd_type cmd,
   input  wire logic [AW-1:0]    rd_addr,
   input  wire htw_pkg::req_type req_data,
   output htw_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output htw_pkg::rsp_type      rsp_data
);

   logic [TABLE_DEPTH-1:0] valid_ff, due_ff;
   logic [31:0]            mem_id  [TABLE_DEPTH];
   logic [63:0]            mem_exp [TABLE_DEPTH];

   logic [63:0]   now_ff;
   logic [31:0]   next_id_ff, delay_ff, target_ff;
   logic          rd_live_ff;
   logic [AW-1:0] rd_slot_ff;
   logic [31:0]   rd_id_ff;
   logic [63:0]   rd_exp_ff;
   logic          best_have_ff, found_ff;
   logic [AW-1:0] best_slot_ff;
   logic [31:0]   best_id_ff;
   logic [63:0]   best_exp_ff;
   logic          le_ff;
   logic [63:0]   diff_ff;
   logic          rsp_valid_ff;
   htw_pkg::rsp_type rsp_ff, rsp_in;

   logic          free_hit;
   logic [AW-1:0] free_idx;
   logic          due_rest, fire_last, out_free;
   logic          rd_valid, mark_due;

   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_hit = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   assign due_rest  = |(due_ff & ~(TABLE_DEPTH'(1) << best_slot_ff));
   assign fire_last = cmd.fire_final | ~due_rest;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rd_valid  = valid_ff[rd_slot_ff];
   assign mark_due  = rd_valid && (rd_exp_ff[BUCKET_BITS-1:0] == now_ff[BUCKET_BITS-1:0])
                      && (rd_exp_ff <= now_ff);

   assign sts.out_free  = out_free;
   assign sts.any_due   = |due_ff;
   assign sts.fire_last = fire_last;

   // slot memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.emit && cmd.emit_sel == htw_pkg::EMIT_SCHED && free_hit) begin
         mem_id[free_idx]  <= next_id_ff;
         mem_exp[free_idx] <= now_ff + {32'd0, delay_ff};
      end
      rd_id_ff   <= mem_id[rd_addr];
      rd_exp_ff  <= mem_exp[rd_addr];
      rd_slot_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         due_ff       <= '0;
         now_ff       <= '0;
         next_id_ff   <= '0;
         rd_live_ff   <= 1'b0;
         best_have_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_live_ff <= cmd.issue;
         if (cmd.load) begin
            delay_ff  <= req_data.delay_ticks;
            target_ff <= req_data.target_id;
            if (req_data.mode == htw_pkg::MODE_TICK) now_ff <= now_ff + 64'd1;
         end
         if (cmd.clear_best) begin
            best_have_ff <= 1'b0;
            found_ff     <= 1'b0;
         end else if (rd_live_ff) begin
            case (cmd.scan_op)
               htw_pkg::SCAN_CANCEL: begin
                  if (!found_ff && rd_valid && rd_id_ff == target_ff) begin
                     found_ff             <= 1'b1;
                     valid_ff[rd_slot_ff] <= 1'b0;
                  end
               end
               htw_pkg::SCAN_MARK: due_ff[rd_slot_ff] <= mark_due;
               htw_pkg::SCAN_FIND: begin
                  if (due_ff[rd_slot_ff] && (!best_have_ff || rd_id_ff < best_id_ff)) begin
                     best_have_ff <= 1'b1;
                     best_slot_ff <= rd_slot_ff;
                     best_id_ff   <= rd_id_ff;
                  end
               end
               htw_pkg::SCAN_QUERY: begin
                  if (rd_valid && (!best_have_ff || rd_exp_ff < best_exp_ff)) begin
                     best_have_ff <= 1'b1;
                     best_exp_ff  <= rd_exp_ff;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.emit) begin
            case (cmd.emit_sel)
               htw_pkg::EMIT_SCHED: begin
                  if (free_hit) begin
                     valid_ff[free_idx] <= 1'b1;
                     next_id_ff         <= next_id_ff + 32'd1;
                  end
               end
               htw_pkg::EMIT_FIRE: begin
                  valid_ff[best_slot_ff] <= 1'b0;
                  due_ff[best_slot_ff]   <= 1'b0;
               end
               default: ;
            endcase
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.qcalc) begin
         le_ff   <= best_exp_ff <= now_ff;
         diff_ff <= best_exp_ff - now_ff;
      end
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.last        = 1'b1;
      case (cmd.emit_sel)
         htw_pkg::EMIT_SCHED: begin
            rsp_in.kind     = htw_pkg::KIND_SCHED;
            rsp_in.ok       = free_hit;
            rsp_in.timer_id = free_hit ? next_id_ff : 32'd0;
         end
         htw_pkg::EMIT_CANCEL: begin
            rsp_in.kind     = htw_pkg::KIND_CANCEL;
            rsp_in.ok       = found_ff;
            rsp_in.timer_id = target_ff;
         end
         htw_pkg::EMIT_FIRE: begin
            rsp_in.kind     = htw_pkg::KIND_FIRED;
            rsp_in.ok       = 1'b1;
            rsp_in.timer_id = best_id_ff;
            rsp_in.last     = fire_last;
         end
         htw_pkg::EMIT_NONE: rsp_in.kind = htw_pkg::KIND_NONE;
         htw_pkg::EMIT_QUERY: begin
            rsp_in.kind = htw_pkg::KIND_QUERY;
            rsp_in.ok   = 1'b1;
            if (!best_have_ff) rsp_in.next_expiry = -32'sd1;
            else if (le_ff) rsp_in.next_expiry = 32'sd0;
            else if (diff_ff[63:31] != 33'd0) rsp_in.next_expiry = 32'sh7fffffff;
            else rsp_in.next_expiry = signed'({1'b0, diff_ff[30:0]});
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/htw_control.sv
`timescale 1ns / 1ps
`default_nettype none
module htw_control #(
   parameter int TABLE_DEPTH = htw_pkg::TABLE_DEPTH_DEF,
   localparam int AW = $clog2(TABLE_DEPTH),
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_mode,
   input  wire htw_pkg::sts_type sts,
   output htw_pkg::cmd_type      cmd,
   output logic [AW-1:0]         rd_addr
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SCHED = 4'd1;
   localparam logic [3:0] ST_CSCAN = 4'd2;
   localparam logic [3:0] ST_CEMIT = 4'd3;
   localparam logic [3:0] ST_MSCAN = 4'd4;
   localparam logic [3:0] ST_TPICK = 4'd5;
   localparam logic [3:0] ST_FSCAN = 4'd6;
   localparam logic [3:0] ST_FEMIT = 4'd7;
   localparam logic [3:0] ST_QSCAN = 4'd8;
   localparam logic [3:0] ST_QCALC = 4'd9;
   localparam logic [3:0] ST_QEMIT = 4'd10;

   logic [3:0]                      state_ff, state_in;
   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic [htw_pkg::FIRE_CNT_W-1:0]  fire_ff, fire_in;
   logic                            scan_end;

   assign scan_end  = cnt_ff == CW'(TABLE_DEPTH);
   assign req_stall = state_ff != ST_IDLE;
   assign rd_addr   = cmd.issue ? cnt_ff[AW-1:0] : '0;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      fire_in        = fire_ff;
      cmd            = '0;
      cmd.fire_final = fire_ff == htw_pkg::FIRE_CNT_W'(htw_pkg::MAX_RESULTS - 1);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load       = 1'b1;
               cmd.clear_best = 1'b1;
               cnt_in         = '0;
               case (req_mode)
                  htw_pkg::MODE_SCHED:  state_in = ST_SCHED;
                  htw_pkg::MODE_CANCEL: state_in = ST_CSCAN;
                  htw_pkg::MODE_TICK:   state_in = ST_MSCAN;
                  default:              state_in = ST_QSCAN;
               endcase
            end
         end
         ST_SCHED: begin
            cmd.emit_sel = htw_pkg::EMIT_SCHED;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CSCAN, ST_MSCAN, ST_FSCAN, ST_QSCAN: begin
            case (state_ff)
               ST_CSCAN: cmd.scan_op = htw_pkg::SCAN_CANCEL;
               ST_MSCAN: cmd.scan_op = htw_pkg::SCAN_MARK;
               ST_FSCAN: cmd.scan_op = htw_pkg::SCAN_FIND;
               default:  cmd.scan_op = htw_pkg::SCAN_QUERY;
            endcase
            if (!scan_end) begin
               cmd.issue = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end else begin
               case (state_ff)
                  ST_CSCAN: state_in = ST_CEMIT;
                  ST_MSCAN: state_in = ST_TPICK;
                  ST_FSCAN: state_in = ST_FEMIT;
                  default:  state_in = ST_QCALC;
               endcase
            end
         end
         ST_CEMIT: begin
            cmd.emit_sel = htw_pkg::EMIT_CANCEL;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_TPICK: begin
            cmd.emit_sel = htw_pkg::EMIT_NONE;
            if (sts.any_due) begin
               cmd.clear_best = 1'b1;
               cnt_in         = '0;
               fire_in        = '0;
               state_in       = ST_FSCAN;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FEMIT: begin
            cmd.emit_sel = htw_pkg::EMIT_FIRE;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.fire_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.clear_best = 1'b1;
                  cnt_in         = '0;
                  fire_in        = fire_ff + htw_pkg::FIRE_CNT_W'(1);
                  state_in       = ST_FSCAN;
               end
            end
         end
         ST_QCALC: begin
            cmd.qcalc = 1'b1;
            state_in  = ST_QEMIT;
         end
         ST_QEMIT: begin
            cmd.emit_sel = htw_pkg::EMIT_QUERY;
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         fire_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         fire_ff  <= fire_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/hashed_timer_wheel_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Hashed timer wheel over TABLE_DEPTH timer slots. One request is in work at
// a time. Schedule finds a free slot by a priority encoder over the valid bits.
// Cancel walks the slot memory one slot a cycle through its single registered
// read port. Query walks the slots likewise and then adds a distance compare
// step. A tick walks the slots to mark the due ones and then decides, which is
// all it does when nothing fires. Each timer fired adds a further walk to pick
// the lowest due id; at most MAX_RESULTS timers fire per tick. A finished result
// sits in the output register, so the next request is taken while it waits for
// its transfer; a result that finds the register still occupied waits until it
// empties.
module hashed_timer_wheel_unit #(
   parameter int TABLE_DEPTH = htw_pkg::TABLE_DEPTH_DEF,
   parameter int BUCKET_BITS = htw_pkg::BUCKET_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire htw_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output htw_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);

   htw_pkg::cmd_type cmd;
   htw_pkg::sts_type sts;
   logic [AW-1:0]    rd_addr;

   // sequencer: request decode, slot walk counter, fired count
   htw_control #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_data.mode),
      .sts       (sts),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   // slot store, tick counter, id counter, scan compare and result register
   htw_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .BUCKET_BITS(BUCKET_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .req_data  (req_data),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

   localparam int DEPTH = htw_pkg::TABLE_DEPTH_DEF;
   localparam int BBITS = htw_pkg::BUCKET_BITS_DEF;
   localparam int WHEEL = 1 << BBITS;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   htw_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   htw_pkg::rsp_type rsp_data;

   always #10 clock = ~clock;

   hashed_timer_wheel_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // shadow copy of the timer table
   bit          wheel_valid[DEPTH];
   logic [31:0] wheel_id[DEPTH];
   logic [63:0] wheel_expiry[DEPTH];
   logic [63:0] wheel_now;
   logic [31:0] wheel_next_id;

   htw_pkg::rsp_type pending_rsp[$];
   int      errors = 0;
   int      n_rsp = 0;
   int      n_fired = 0;
   int      n_sent = 0;
   bit      hold_off = 1'b0;

   function automatic htw_pkg::rsp_type mk(logic [2:0] k, logic [31:0] id, logic ok,
                                           logic [31:0] nx, logic lst);
      htw_pkg::rsp_type r;
      r.kind = k; r.timer_id = id; r.ok = ok; r.next_expiry = nx; r.last = lst;
      return r;
   endfunction

   task automatic add_rsp(htw_pkg::rsp_type r);
      pending_rsp = {pending_rsp, r};
   endtask

   // work out the results of one request and advance the shadow table
   task automatic predict_wheel(htw_pkg::req_type q);
      int          i;
      int          best;
      int          n;
      bit          due[DEPTH];
      bit          any;
      logic [63:0] earliest;
      logic [63:0] d;
      logic [63:0] bmask;
      logic [31:0] ans;
      bmask = 64'(WHEEL - 1);
      case (q.mode)
         htw_pkg::MODE_SCHED: begin
            best = -1;
            for (i = 0; i < DEPTH; i++)
               if (!wheel_valid[i] && best < 0) best = i;
            if (best < 0) begin
               add_rsp(mk(htw_pkg::KIND_SCHED, '0, 1'b0, '0, 1'b1));
            end else begin
               wheel_valid[best]  = 1'b1;
               wheel_id[best]     = wheel_next_id;
               wheel_expiry[best] = wheel_now + {32'd0, q.delay_ticks};
               add_rsp(mk(htw_pkg::KIND_SCHED, wheel_next_id, 1'b1, '0, 1'b1));
               wheel_next_id++;
            end
         end
         htw_pkg::MODE_CANCEL: begin
            best = -1;
            for (i = 0; i < DEPTH; i++)
               if (best < 0 && wheel_valid[i] && wheel_id[i] == q.target_id) best = i;
            if (best >= 0) wheel_valid[best] = 1'b0;
            add_rsp(mk(htw_pkg::KIND_CANCEL, q.target_id, best >= 0, '0, 1'b1));
         end
         htw_pkg::MODE_TICK: begin
            wheel_now++;
            for (i = 0; i < DEPTH; i++)
               due[i] = wheel_valid[i] && ((wheel_expiry[i] & bmask) == (wheel_now & bmask))
                        && wheel_expiry[i] <= wheel_now;
            n = 0;
            while (n < htw_pkg::MAX_RESULTS) begin
               best = -1;
               for (i = 0; i < DEPTH; i++)
                  if (due[i] && (best < 0 || wheel_id[i] < wheel_id[best])) best = i;
               if (best < 0) break;
               due[best] = 1'b0;
               wheel_valid[best] = 1'b0;
               add_rsp(mk(htw_pkg::KIND_FIRED, wheel_id[best], 1'b1, '0, 1'b0));
               n++;
            end
            if (n == 0) add_rsp(mk(htw_pkg::KIND_NONE, '0, 1'b0, '0, 1'b1));
            else pending_rsp[$].last = 1'b1;
         end
         default: begin
            any = 1'b0;
            earliest = '0;
            for (i = 0; i < DEPTH; i++)
               if (wheel_valid[i] && (!any || wheel_expiry[i] < earliest)) begin
                  earliest = wheel_expiry[i];
                  any = 1'b1;
               end
            if (!any) ans = 32'hFFFF_FFFF;
            else if (earliest <= wheel_now) ans = '0;
            else begin
               d = earliest - wheel_now;
               ans = (d > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : d[31:0];
            end
            add_rsp(mk(htw_pkg::KIND_QUERY, '0, 1'b1, ans, 1'b1));
         end
      endcase
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one request transfer; prediction taken at acceptance
   task automatic send_req(logic [1:0] m, logic [31:0] dly, logic [31:0] tgt);
      int g;
      htw_pkg::req_type q;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      q.mode = m; q.delay_ticks = dly; q.target_id = tgt;
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_wheel(q);
      n_sent++;
   endtask

   task automatic tick_n(int n);
      repeat (n) send_req(htw_pkg::MODE_TICK, $urandom, $urandom);
   endtask

   // receiver stall pattern; a long hold-off on request
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < 25);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected result: expected none actual %p", $time, rsp_data);
            errors++;
         end else begin
            htw_pkg::rsp_type e;
            e = pending_rsp.pop_front();
            if (e.kind == htw_pkg::KIND_FIRED) n_fired++;
            if (e.kind !== rsp_data.kind || e.timer_id !== rsp_data.timer_id ||
                e.ok !== rsp_data.ok || e.next_expiry !== rsp_data.next_expiry ||
                e.last !== rsp_data.last) begin
               $display("%0t mismatch: expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_req(htw_pkg::MODE_QUERY, '0, '0);              // empty table answers -1
      send_req(htw_pkg::MODE_TICK, '0, '0);               // nothing fires
      send_req(htw_pkg::MODE_CANCEL, '0, 32'hFFFF_FFFF);  // cancel on empty
      send_req(htw_pkg::MODE_SCHED, 32'd0, '0);           // zero delay: full turn
      send_req(htw_pkg::MODE_SCHED, 32'hFFFF_FFFF, '0);   // far expiry, cancelled below
      send_req(htw_pkg::MODE_SCHED, 32'd2, '0);
      send_req(htw_pkg::MODE_QUERY, '0, '0);
      send_req(htw_pkg::MODE_CANCEL, '0, 32'd1);
      send_req(htw_pkg::MODE_CANCEL, '0, 32'd1);          // already gone
      tick_n(2);                                          // id 2 fires
      send_req(htw_pkg::MODE_QUERY, '0, '0);
      tick_n(WHEEL - 2);                                  // id 0 fires a turn later
      send_req(htw_pkg::MODE_QUERY, '0, '0);
   endtask

   // fill the table, refuse one more, then fire everything in one tick
   task automatic test_full_table();
      int i;
      for (i = 0; i < DEPTH; i++) send_req(htw_pkg::MODE_SCHED, 32'd3, $urandom);
      send_req(htw_pkg::MODE_SCHED, 32'd5, '0);
      send_req(htw_pkg::MODE_QUERY, '0, '0);
      tick_n(3);
   endtask

   // mostly well-formed traffic: schedules with short delays, ticks, cancels, queries
   task automatic test_random(int n);
      int i;
      int r;
      logic [31:0] dly;
      logic [31:0] tgt;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            case ($urandom_range(0, 9))
               0: dly = $urandom;
               1: dly = WHEEL * $urandom_range(1, 3) + $urandom_range(0, 3);
               default: dly = $urandom_range(0, 12);
            endcase
            send_req(htw_pkg::MODE_SCHED, dly, $urandom);
         end else if (r < 50) begin
            tgt = ($urandom_range(0, 3) == 0) ? $urandom
                  : wheel_next_id - $urandom_range(1, 12);
            send_req(htw_pkg::MODE_CANCEL, $urandom, tgt);
         end else if (r < 88) send_req(htw_pkg::MODE_TICK, $urandom, $urandom);
         else send_req(htw_pkg::MODE_QUERY, $urandom, $urandom);
      end
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(12);
      join
   endtask

   initial begin
      int k;
      for (k = 0; k < DEPTH; k++) wheel_valid[k] = 1'b0;
      wheel_now = '0;
      wheel_next_id = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_backpressure();
      test_random(64);
      req_valid <= 1'b0;
      k = 0;
      while (pending_rsp.size() != 0 && k < 200000) begin
         @(posedge clock);
         k++;
      end
      repeat (100) @(posedge clock);
      $display("%0d requests sent, %0d results checked, %0d timers fired;", n_sent,
               n_rsp, n_fired);
      $display("covered schedule, cancel, tick, query, full table and long stall.");
      if (errors == 0 && pending_rsp.size() == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #200ms;
      $display("tb_top: FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
rtl/htw_pkg.sv
rtl/htw_datapath.sv
rtl/htw_control.sv
rtl/hashed_timer_wheel_unit.sv
tb/tb_top.sv
